/* src/skpm_pkg.sv */
// Shared definitions for the sorted keyword prefix matcher.
// Holds parameter defaults, register indexes and result status codes; no dependencies.
`default_nettype none

package skpm_pkg;

	localparam int NUM_ENTRIES_DEF    = 8;
	localparam int MAX_KEY_LEN_DEF    = 16;
	localparam int NUM_SEPARATORS_DEF = 4;

	// Number of separator registers on the configuration port.
	localparam int SEP_REGS = 4;

	localparam logic [7:0] SEP_A_RESET = 8'd32;

	typedef enum logic [2:0] {
		REG_ENTRY_COUNT = 3'd0,
		REG_SEPARATOR_A = 3'd1,
		REG_SEPARATOR_B = 3'd2,
		REG_SEPARATOR_C = 3'd3,
		REG_SEPARATOR_D = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_CONTINUE    = 3'd0,
		ST_MATCHED     = 3'd1,
		ST_NOT_IN_LIST = 3'd2,
		ST_STRING_END  = 3'd3,
		ST_IGNORED     = 3'd4
	} status_t;

endpackage

`default_nettype wire

/* src/sorted_keyword_prefix_matcher_unit.sv */
// Sorted keyword prefix matcher: top level with sequencer, window registers and config port.
// Depends on skpm_pkg and skpm_kwmem.
//
// A load item (mode 0) writes one keyword character into the table and gives no result.
// A match item (mode 1) yields exactly one result. Ignored items and string ends go
// straight to the response state and from there to the output register. Other characters
// scan the current keyword window one table entry per cycle through the single table read
// port; the scan covers at most NUM_ENTRIES entries and stops early when the window closes,
// a separator matches or the window is empty. A stalled output holds the result back.
// The input is not ready while a match item is at work. Configuration writes are accepted
// in every cycle.
`default_nettype none

module sorted_keyword_prefix_matcher_unit #(
	parameter int NUM_ENTRIES    = skpm_pkg::NUM_ENTRIES_DEF,
	parameter int MAX_KEY_LEN    = skpm_pkg::MAX_KEY_LEN_DEF,
	parameter int NUM_SEPARATORS = skpm_pkg::NUM_SEPARATORS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       mode,
	input  wire logic       start_req,
	input  wire logic [7:0] char_in,
	input  wire logic [2:0] entry,
	input  wire logic [3:0] offset,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [2:0] status,
	output logic      [2:0] match_index,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	localparam int DEPTH = NUM_ENTRIES * MAX_KEY_LEN;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = $clog2(NUM_ENTRIES + 1);
	localparam int PW    = $clog2(MAX_KEY_LEN + 1);
	localparam int NSEP  = (NUM_SEPARATORS < skpm_pkg::SEP_REGS) ?
		NUM_SEPARATORS : skpm_pkg::SEP_REGS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

	state_t             state_q;
	logic [3:0]         entry_count_q;
	logic [7:0]         sep_q [skpm_pkg::SEP_REGS];
	logic [EW-1:0]      wf_q;
	logic [EW-1:0]      wl_q;
	logic [PW-1:0]      pos_q;
	logic               fin_q;
	logic [EW-1:0]      w_q;
	logic [EW-1:0]      cmp_w_q;
	logic               rd_pend_q;
	logic               found_q;
	logic               is_sep_q;
	logic [7:0]         want_q;
	skpm_pkg::status_t  res_status_q;
	logic [2:0]         res_idx_q;
	logic               out_valid_q;
	skpm_pkg::status_t  status_q;
	logic [2:0]         match_index_q;

	logic               in_xfer;
	logic               cfg_xfer;
	logic               is_sep;
	logic [EW-1:0]      count_sat;
	logic               mem_wr_en;
	logic [AW-1:0]      mem_wr_addr;
	logic               mem_rd_en;
	logic [AW-1:0]      mem_rd_addr;
	logic [7:0]         mem_rd_data;
	logic [7:0]         data_eff;
	logic               hit;
	logic               brk_match;
	logic               brk_close;
	logic               scan_end;
	logic [PW-1:0]      pos_inc;
	logic               resp_load;

	assign in_ready    = (state_q == S_IDLE);
	assign cfg_ready   = 1'b1;
	assign in_xfer     = in_valid && in_ready;
	assign cfg_xfer    = cfg_valid && cfg_ready;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign match_index = match_index_q;
	assign resp_load   = (state_q == S_RESP) && (!out_valid_q || out_ready);

	always_comb begin
		is_sep = 1'b0;
		for (int i = 0; i < NSEP; i++) begin
			if (sep_q[i] != 8'd0 && sep_q[i] == char_in) begin
				is_sep = 1'b1;
			end
		end
	end

	assign count_sat = (32'(entry_count_q) > NUM_ENTRIES) ?
		EW'(NUM_ENTRIES) : EW'(entry_count_q);

	assign mem_wr_en   = in_xfer && !mode && (32'(entry) < NUM_ENTRIES) &&
		(32'(offset) < MAX_KEY_LEN);
	assign mem_wr_addr = AW'(32'(entry) * MAX_KEY_LEN + 32'(offset));

	// Positions at or past the key length read as NUL, so the address is held in range.
	always_comb begin
		if (32'(pos_q) >= MAX_KEY_LEN) begin
			mem_rd_addr = AW'(32'(w_q) * MAX_KEY_LEN);
			data_eff    = 8'd0;
		end else begin
			mem_rd_addr = AW'(32'(w_q) * MAX_KEY_LEN + 32'(pos_q));
			data_eff    = mem_rd_data;
		end
	end

	assign hit       = rd_pend_q && (data_eff == want_q);
	assign brk_match = hit && is_sep_q;
	assign brk_close = rd_pend_q && !hit && found_q;
	assign mem_rd_en = (state_q == S_SCAN) && !brk_match && !brk_close && (w_q < wl_q);
	assign scan_end  = (state_q == S_SCAN) && !rd_pend_q && (w_q >= wl_q);
	assign pos_inc   = (32'(pos_q) < MAX_KEY_LEN) ? pos_q + PW'(1) : pos_q;

	skpm_kwmem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_kwmem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (char_in),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			sep_q[0]      <= skpm_pkg::SEP_A_RESET;
			for (int i = 1; i < skpm_pkg::SEP_REGS; i++) begin
				sep_q[i] <= 8'd0;
			end
		end else if (cfg_xfer) begin
			case (cfg_index)
				skpm_pkg::REG_ENTRY_COUNT: entry_count_q <= cfg_data[3:0];
				skpm_pkg::REG_SEPARATOR_A: sep_q[0] <= cfg_data;
				skpm_pkg::REG_SEPARATOR_B: sep_q[1] <= cfg_data;
				skpm_pkg::REG_SEPARATOR_C: sep_q[2] <= cfg_data;
				skpm_pkg::REG_SEPARATOR_D: sep_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			wf_q          <= '0;
			wl_q          <= '0;
			pos_q         <= '0;
			fin_q         <= 1'b1;
			w_q           <= '0;
			cmp_w_q       <= '0;
			rd_pend_q     <= 1'b0;
			found_q       <= 1'b0;
			is_sep_q      <= 1'b0;
			want_q        <= 8'd0;
			res_status_q  <= skpm_pkg::ST_CONTINUE;
			res_idx_q     <= 3'd0;
			out_valid_q   <= 1'b0;
			status_q      <= skpm_pkg::ST_CONTINUE;
			match_index_q <= 3'd0;
		end else begin
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer && mode) begin
						res_idx_q <= 3'd0;
						if (start_req) begin
							wf_q  <= '0;
							wl_q  <= count_sat;
							pos_q <= '0;
						end
						if (fin_q && !start_req) begin
							res_status_q <= skpm_pkg::ST_IGNORED;
							state_q      <= S_RESP;
						end else if (char_in == 8'd0) begin
							res_status_q <= skpm_pkg::ST_STRING_END;
							fin_q        <= 1'b1;
							state_q      <= S_RESP;
						end else begin
							fin_q     <= 1'b0;
							is_sep_q  <= is_sep;
							want_q    <= is_sep ? 8'd0 : char_in;
							w_q       <= start_req ? '0 : wf_q;
							found_q   <= 1'b0;
							rd_pend_q <= 1'b0;
							state_q   <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_pend_q <= mem_rd_en;
					if (mem_rd_en) begin
						cmp_w_q <= w_q;
						w_q     <= w_q + EW'(1);
					end
					// The first hit of a letter moves the window start; a later miss closes it.
					if (hit && !is_sep_q && !found_q) begin
						wf_q    <= cmp_w_q;
						found_q <= 1'b1;
					end
					if (brk_match) begin
						res_status_q <= skpm_pkg::ST_MATCHED;
						res_idx_q    <= 3'(cmp_w_q);
						fin_q        <= 1'b1;
						state_q      <= S_RESP;
					end else if (brk_close) begin
						wl_q         <= cmp_w_q;
						res_status_q <= skpm_pkg::ST_CONTINUE;
						pos_q        <= pos_inc;
						state_q      <= S_RESP;
					end else if (scan_end) begin
						if (found_q) begin
							res_status_q <= skpm_pkg::ST_CONTINUE;
							pos_q        <= pos_inc;
						end else begin
							res_status_q <= skpm_pkg::ST_NOT_IN_LIST;
							fin_q        <= 1'b1;
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (resp_load) begin
						status_q      <= res_status_q;
						match_index_q <= res_idx_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		wf_q <= wl_q)
		else $error("window start passed window end");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) <= MAX_KEY_LEN)
		else $error("character position beyond key length");

	a_match_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && mode) |=> !in_ready)
		else $error("input ready right after a match transfer");

	a_scan_window: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> (cmp_w_q < wl_q))
		else $error("compared entry outside the window");

endmodule

`default_nettype wire

/* src/skpm_kwmem.sv */
// Keyword table storage: one write port and one read port with registered read data.
// Standalone; used by sorted_keyword_prefix_matcher_unit.
`default_nettype none

module skpm_kwmem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [7:0]    rd_data
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire
